/* rtl/core/ttc_pkg.sv */
// ----------------------------------------------------------------------------
// Triangle tangent package
// Widths, codes and handshake structs shared by the tangent core files.
// ----------------------------------------------------------------------------
package ttc_pkg;

   localparam int POS_W      = 32;
   localparam int UV_W       = 16;
   localparam int EDGE_W     = POS_W + 1;
   localparam int DUV_W      = UV_W + 1;
   localparam int PROD_W     = EDGE_W + DUV_W;
   localparam int ACC_W      = PROD_W + 1;
   localparam int DET_W      = 2 * DUV_W + 1;
   localparam int NMAG_W     = PROD_W;
   localparam int Q_W        = 32;
   localparam int FRAC_SHIFT = 12;
   localparam int HI_W       = NMAG_W + FRAC_SHIFT - Q_W;
   localparam int LO_W       = Q_W - FRAC_SHIFT;
   localparam int CNT_W      = $clog2(Q_W);
   localparam int NUM_AXES   = 3;
   localparam int AXIS_W     = $clog2(NUM_AXES);

   localparam logic [Q_W-1:0] SAT_POS = {1'b0, {(Q_W-1){1'b1}}};
   localparam logic [Q_W-1:0] SAT_NEG = {1'b1, {(Q_W-1){1'b0}}};

   localparam logic [1:0] CORNER_FIRST  = 2'd0;
   localparam logic [1:0] CORNER_SECOND = 2'd1;
   localparam logic [1:0] CORNER_THIRD  = 2'd2;

   typedef struct packed {
      logic              start;
      logic              neg;
      logic [NMAG_W-1:0] num_mag;
      logic [DET_W-1:0]  den_mag;
   } div_req_type;

   typedef struct packed {
      logic           done;
      logic [Q_W-1:0] quot;
   } div_rsp_type;

endpackage

/* rtl/core/ttc_if.sv */
// ----------------------------------------------------------------------------
// Triangle tangent stream interfaces
// Vertex and tangent channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface ttc_req_if;
   logic                             valid;
   logic                             ready;
   logic signed [ttc_pkg::POS_W-1:0] pos_x;
   logic signed [ttc_pkg::POS_W-1:0] pos_y;
   logic signed [ttc_pkg::POS_W-1:0] pos_z;
   logic signed [ttc_pkg::UV_W-1:0]  tex_u;
   logic signed [ttc_pkg::UV_W-1:0]  tex_v;

   modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

interface ttc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic signed [ttc_pkg::Q_W-1:0] tangent_x;
   logic signed [ttc_pkg::Q_W-1:0] tangent_y;
   logic signed [ttc_pkg::Q_W-1:0] tangent_z;

   modport source (output valid, tangent_x, tangent_y, tangent_z, input ready);
   modport sink (input valid, tangent_x, tangent_y, tangent_z, output ready);
endinterface

/* rtl/core/ttc_div.sv */
// ----------------------------------------------------------------------------
// Triangle tangent divider
// Radix-2 restoring divider, one quotient bit per cycle, with saturation.
// ----------------------------------------------------------------------------
module ttc_div (
   input  logic                 clock,
   input  logic                 reset,
   input  ttc_pkg::div_req_type div_req,
   output ttc_pkg::div_rsp_type div_rsp
);
   import ttc_pkg::*;

   typedef enum logic [1:0] {
      D_IDLE,
      D_CHECK,
      D_RUN,
      D_FIN
   } dstate_type;

   dstate_type        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [DET_W-1:0]  rem_ff, rem_in;
   logic [DET_W-1:0]  den_ff, den_in;
   logic [Q_W-1:0]    low_ff, low_in;
   logic [Q_W-1:0]    quot_ff, quot_in;
   logic              neg_ff, neg_in;
   logic              ovf_ff, ovf_in;
   logic [DET_W:0]    rem_shift;
   logic [DET_W:0]    rem_diff;
   logic [Q_W-1:0]    quot_neg;
   logic              quot_big;

   assign rem_shift = {rem_ff, low_ff[Q_W-1]};
   assign rem_diff  = rem_shift - {1'b0, den_ff};
   assign quot_neg  = (~quot_ff) + Q_W'(1);
   assign quot_big  = quot_ff[Q_W-1] && (quot_ff[Q_W-2:0] != '0);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      low_in   = low_ff;
      quot_in  = quot_ff;
      neg_in   = neg_ff;
      ovf_in   = ovf_ff;
      unique case (state_ff)
         D_IDLE: begin
            if (div_req.start) begin
               rem_in   = DET_W'(div_req.num_mag[NMAG_W-1 -: HI_W]);
               low_in   = {div_req.num_mag[LO_W-1:0], {FRAC_SHIFT{1'b0}}};
               den_in   = div_req.den_mag;
               neg_in   = div_req.neg;
               quot_in  = '0;
               state_in = D_CHECK;
            end
         end
         D_CHECK: begin
            ovf_in   = (rem_ff >= den_ff);
            count_in = CNT_W'(Q_W - 1);
            state_in = (rem_ff >= den_ff) ? D_FIN : D_RUN;
         end
         D_RUN: begin
            if (!rem_diff[DET_W]) begin
               rem_in  = rem_diff[DET_W-1:0];
               quot_in = {quot_ff[Q_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_shift[DET_W-1:0];
               quot_in = {quot_ff[Q_W-2:0], 1'b0};
            end
            low_in   = {low_ff[Q_W-2:0], 1'b0};
            count_in = count_ff - CNT_W'(1);
            if (count_ff == '0) begin
               state_in = D_FIN;
            end
         end
         D_FIN: begin
            state_in = D_IDLE;
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_comb begin
      div_rsp.done = (state_ff == D_FIN);
      if (neg_ff) begin
         div_rsp.quot = (ovf_ff || quot_big) ? SAT_NEG : quot_neg;
      end else begin
         div_rsp.quot = (ovf_ff || quot_ff[Q_W-1]) ? SAT_POS : quot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
      end else begin
         state_ff <= state_in;
      end
      count_ff <= count_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      low_ff   <= low_in;
      quot_ff  <= quot_in;
      neg_ff   <= neg_in;
      ovf_ff   <= ovf_in;
   end

endmodule

/* rtl/core/triangle_tangent_compute_core.sv */
// ----------------------------------------------------------------------------
// Triangle tangent compute core
// The first two vertices of a triangle are stored. The third runs the
// determinant on the shared multiplier (two products, a subtract), then per
// axis two products, a subtract and a 32-step divide; a zero determinant
// gives zero tangents. The divider loop sets the rate. Reset is synchronous
// and clears the corner count and all handshake state, not the corner stores.
// ----------------------------------------------------------------------------
module triangle_tangent_compute_core (
   input  logic      clock,
   input  logic      reset,
   ttc_req_if.sink   req_stream,
   ttc_rsp_if.source rsp_stream
);
   import ttc_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL0,
      S_MUL1,
      S_SUB,
      S_DIV_WAIT,
      S_PUSH
   } state_type;

   state_type                state_ff, state_in;
   logic [1:0]               corner_count_ff, corner_count_in;
   logic                     det_phase_ff, det_phase_in;
   logic [AXIS_W-1:0]        axis_ff, axis_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic signed [POS_W-1:0]  first_pos_ff [NUM_AXES];
   logic signed [POS_W-1:0]  first_pos_in [NUM_AXES];
   logic signed [POS_W-1:0]  second_pos_ff [NUM_AXES];
   logic signed [POS_W-1:0]  second_pos_in [NUM_AXES];
   logic signed [UV_W-1:0]   first_u_ff, first_u_in, first_v_ff, first_v_in;
   logic signed [UV_W-1:0]   second_u_ff, second_u_in, second_v_ff, second_v_in;
   logic signed [EDGE_W-1:0] e1_ff [NUM_AXES];
   logic signed [EDGE_W-1:0] e1_in [NUM_AXES];
   logic signed [EDGE_W-1:0] e2_ff [NUM_AXES];
   logic signed [EDGE_W-1:0] e2_in [NUM_AXES];
   logic signed [DUV_W-1:0]  du1_ff, du1_in, dv1_ff, dv1_in;
   logic signed [DUV_W-1:0]  du2_ff, du2_in, dv2_ff, dv2_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [PROD_W-1:0] acc_ff, acc_in;
   logic [DET_W-1:0]         det_mag_ff, det_mag_in;
   logic                     det_neg_ff, det_neg_in;
   logic [Q_W-1:0]           tan_ff [NUM_AXES];
   logic [Q_W-1:0]           tan_in [NUM_AXES];
   logic [Q_W-1:0]           rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in, rsp_z_ff, rsp_z_in;

   logic                     req_accept;
   logic signed [DUV_W-1:0]  mul_a;
   logic signed [EDGE_W-1:0] mul_b;
   logic signed [PROD_W-1:0] mul_res;
   logic signed [ACC_W-1:0]  diff;
   logic [ACC_W-1:0]         diff_mag;
   div_req_type              div_req;
   div_rsp_type              div_rsp;

   assign req_stream.ready = (state_ff == S_IDLE);
   assign req_accept       = req_stream.valid && req_stream.ready;

   assign rsp_stream.valid     = rsp_valid_ff;
   assign rsp_stream.tangent_x = rsp_x_ff;
   assign rsp_stream.tangent_y = rsp_y_ff;
   assign rsp_stream.tangent_z = rsp_z_ff;

   always_comb begin
      if (det_phase_ff) begin
         mul_a = (state_ff == S_MUL0) ? du1_ff : dv1_ff;
         mul_b = (state_ff == S_MUL0) ? EDGE_W'(dv2_ff) : EDGE_W'(du2_ff);
      end else begin
         mul_a = (state_ff == S_MUL0) ? dv2_ff : dv1_ff;
         mul_b = (state_ff == S_MUL0) ? e1_ff[axis_ff] : e2_ff[axis_ff];
      end
   end

   assign mul_res  = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign diff     = ACC_W'(acc_ff) - ACC_W'(prod_ff);
   assign diff_mag = diff[ACC_W-1] ? ((~diff) + ACC_W'(1)) : diff;

   always_comb begin
      div_req.start   = (state_ff == S_SUB) && !det_phase_ff;
      div_req.neg     = diff[ACC_W-1] ^ det_neg_ff;
      div_req.num_mag = diff_mag[NMAG_W-1:0];
      div_req.den_mag = det_mag_ff;
   end

   ttc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      state_in        = state_ff;
      corner_count_in = corner_count_ff;
      det_phase_in    = det_phase_ff;
      axis_in         = axis_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_stream.ready;
      first_pos_in    = first_pos_ff;
      second_pos_in   = second_pos_ff;
      first_u_in      = first_u_ff;
      first_v_in      = first_v_ff;
      second_u_in     = second_u_ff;
      second_v_in     = second_v_ff;
      e1_in           = e1_ff;
      e2_in           = e2_ff;
      du1_in          = du1_ff;
      dv1_in          = dv1_ff;
      du2_in          = du2_ff;
      dv2_in          = dv2_ff;
      prod_in         = prod_ff;
      acc_in          = acc_ff;
      det_mag_in      = det_mag_ff;
      det_neg_in      = det_neg_ff;
      tan_in          = tan_ff;
      rsp_x_in        = rsp_x_ff;
      rsp_y_in        = rsp_y_ff;
      rsp_z_in        = rsp_z_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               unique case (corner_count_ff)
                  CORNER_FIRST: begin
                     first_pos_in[0] = req_stream.pos_x;
                     first_pos_in[1] = req_stream.pos_y;
                     first_pos_in[2] = req_stream.pos_z;
                     first_u_in      = req_stream.tex_u;
                     first_v_in      = req_stream.tex_v;
                     corner_count_in = CORNER_SECOND;
                  end
                  CORNER_SECOND: begin
                     second_pos_in[0] = req_stream.pos_x;
                     second_pos_in[1] = req_stream.pos_y;
                     second_pos_in[2] = req_stream.pos_z;
                     second_u_in      = req_stream.tex_u;
                     second_v_in      = req_stream.tex_v;
                     corner_count_in  = CORNER_THIRD;
                  end
                  default: begin
                     for (int i = 0; i < NUM_AXES; i++) begin
                        e1_in[i] = EDGE_W'(second_pos_ff[i]) - EDGE_W'(first_pos_ff[i]);
                     end
                     e2_in[0] = EDGE_W'(req_stream.pos_x) - EDGE_W'(first_pos_ff[0]);
                     e2_in[1] = EDGE_W'(req_stream.pos_y) - EDGE_W'(first_pos_ff[1]);
                     e2_in[2] = EDGE_W'(req_stream.pos_z) - EDGE_W'(first_pos_ff[2]);
                     du1_in          = DUV_W'(second_u_ff) - DUV_W'(first_u_ff);
                     dv1_in          = DUV_W'(second_v_ff) - DUV_W'(first_v_ff);
                     du2_in          = DUV_W'(req_stream.tex_u) - DUV_W'(first_u_ff);
                     dv2_in          = DUV_W'(req_stream.tex_v) - DUV_W'(first_v_ff);
                     corner_count_in = CORNER_FIRST;
                     det_phase_in    = 1'b1;
                     axis_in         = '0;
                     state_in        = S_MUL0;
                  end
               endcase
            end
         end
         S_MUL0: begin
            prod_in  = mul_res;
            state_in = S_MUL1;
         end
         S_MUL1: begin
            acc_in   = prod_ff;
            prod_in  = mul_res;
            state_in = S_SUB;
         end
         S_SUB: begin
            if (det_phase_ff) begin
               det_mag_in   = diff_mag[DET_W-1:0];
               det_neg_in   = diff[ACC_W-1];
               det_phase_in = 1'b0;
               if (diff == '0) begin
                  for (int i = 0; i < NUM_AXES; i++) begin
                     tan_in[i] = '0;
                  end
                  state_in = S_PUSH;
               end else begin
                  state_in = S_MUL0;
               end
            end else begin
               state_in = S_DIV_WAIT;
            end
         end
         S_DIV_WAIT: begin
            if (div_rsp.done) begin
               tan_in[axis_ff] = div_rsp.quot;
               if (axis_ff == AXIS_W'(NUM_AXES - 1)) begin
                  state_in = S_PUSH;
               end else begin
                  axis_in  = axis_ff + AXIS_W'(1);
                  state_in = S_MUL0;
               end
            end
         end
         S_PUSH: begin
            if (!rsp_valid_ff || rsp_stream.ready) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = tan_ff[0];
               rsp_y_in     = tan_ff[1];
               rsp_z_in     = tan_ff[2];
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         corner_count_ff <= CORNER_FIRST;
         det_phase_ff    <= 1'b0;
         axis_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         corner_count_ff <= corner_count_in;
         det_phase_ff    <= det_phase_in;
         axis_ff         <= axis_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      first_pos_ff  <= first_pos_in;
      second_pos_ff <= second_pos_in;
      first_u_ff    <= first_u_in;
      first_v_ff    <= first_v_in;
      second_u_ff   <= second_u_in;
      second_v_ff   <= second_v_in;
      e1_ff         <= e1_in;
      e2_ff         <= e2_in;
      du1_ff        <= du1_in;
      dv1_ff        <= dv1_in;
      du2_ff        <= du2_in;
      dv2_ff        <= dv2_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      det_mag_ff    <= det_mag_in;
      det_neg_ff    <= det_neg_in;
      tan_ff        <= tan_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_z_ff      <= rsp_z_in;
   end

endmodule

/* rtl/core/ttc_checker.sv */
// ----------------------------------------------------------------------------
// Triangle tangent port checker
// Watches the core's ports over time and is bound to the tangent compute core.
// ----------------------------------------------------------------------------
module ttc_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [ttc_pkg::Q_W-1:0]   tangent_x,
   input logic [ttc_pkg::Q_W-1:0]   tangent_y,
   input logic [ttc_pkg::Q_W-1:0]   tangent_z
);
   import ttc_pkg::*;

   // A pending tangent transaction must hold its valid and its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable(tangent_x) && $stable(tangent_y) && $stable(tangent_z))
      else $error("tangent transaction dropped or changed while stalled");

   // The core comes out of reset ready for a vertex.
   assert property (@(posedge clock) reset |=> req_ready && !rsp_valid)
      else $error("core not idle after reset");

   // Without a vertex transaction the core stays ready.
   assert property (@(posedge clock) disable iff (reset)
      req_ready && !req_valid |=> req_ready)
      else $error("core left idle without a vertex transaction");

   // A new tangent appears only at the end of a computation.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("tangent transaction raised while the core was idle");

endmodule

bind triangle_tangent_compute_core ttc_checker u_ttc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_stream.valid),
   .req_ready (req_stream.ready),
   .rsp_valid (rsp_stream.valid),
   .rsp_ready (rsp_stream.ready),
   .tangent_x (rsp_stream.tangent_x),
   .tangent_y (rsp_stream.tangent_y),
   .tangent_z (rsp_stream.tangent_z)
);
